// File: rtl/llrp_pkg.sv
// Shared types, constants and codes for the least-loaded replica picker.
package llrp_pkg;

	// Defaults for the top-level parameters
	localparam int SLOTS_DEFAULT     = 16;
	localparam int LOAD_BITS_DEFAULT = 16;

	// Fixed field widths
	localparam int COUNT_W   = 5;
	localparam int TICK_W    = 32;
	localparam int MODE_W    = 2;
	localparam int REPLICA_W = 4;
	localparam int CHOSEN_W  = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [TICK_W-1:0] RECOVERY_RESET = 32'd15000;
	localparam logic [TICK_W-1:0] TICK_MAX       = {TICK_W{1'b1}};

	// Item operation codes
	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_TICK    = 2'd0;
	localparam mode_t MODE_PICK    = 2'd1;
	localparam mode_t MODE_RELEASE = 2'd2;
	localparam mode_t MODE_FAIL    = 2'd3;

	// Configuration register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_REPLICA_COUNT  = 1'd0;
	localparam cfg_idx_t CFG_RECOVERY_TICKS = 1'd1;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_AGE,
		S_SCAN,
		S_BUMP,
		S_REL,
		S_FAIL,
		S_FIN
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;
		logic age;
		logic scan;
		logic bump;
		logic release_one;
		logic fail_one;
		logic sel_best;
		logic sel_replica;
		logic load_out;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic used_empty;
		logic scan_last_used;
		logic scan_last_all;
	} sts_t;

endpackage

// File: rtl/llrp_ctrl.sv
// Controller state machine: sequences one item at a time through the datapath.
module llrp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  llrp_pkg::mode_t      mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	output llrp_pkg::cmd_t       cmd,
	input  llrp_pkg::sts_t       sts
);

	llrp_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= llrp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == llrp_pkg::S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			llrp_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					unique case (mode)
						llrp_pkg::MODE_TICK:    state_d = llrp_pkg::S_AGE;
						llrp_pkg::MODE_PICK:    state_d = sts.used_empty ? llrp_pkg::S_FIN
						                                                 : llrp_pkg::S_SCAN;
						llrp_pkg::MODE_RELEASE: state_d = llrp_pkg::S_REL;
						llrp_pkg::MODE_FAIL:    state_d = llrp_pkg::S_FAIL;
						default:                state_d = llrp_pkg::S_IDLE;
					endcase
				end
			end
			llrp_pkg::S_AGE: begin
				cmd.age = 1'b1;
				if (sts.scan_last_all) begin
					state_d = llrp_pkg::S_FIN;
				end
			end
			llrp_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last_used) begin
					state_d = llrp_pkg::S_BUMP;
				end
			end
			llrp_pkg::S_BUMP: begin
				cmd.bump     = 1'b1;
				cmd.sel_best = 1'b1;
				state_d      = llrp_pkg::S_FIN;
			end
			llrp_pkg::S_REL: begin
				cmd.release_one = 1'b1;
				cmd.sel_replica = 1'b1;
				state_d         = llrp_pkg::S_FIN;
			end
			llrp_pkg::S_FAIL: begin
				cmd.fail_one    = 1'b1;
				cmd.sel_replica = 1'b1;
				state_d         = llrp_pkg::S_FIN;
			end
			llrp_pkg::S_FIN: begin
				cmd.sel_best = 1'b1;
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = llrp_pkg::S_IDLE;
				end
			end
			default: state_d = llrp_pkg::S_IDLE;
		endcase
	end

endmodule

// File: rtl/llrp_dpath.sv
// Datapath: slot table, configuration registers, scan unit and result register.
module llrp_dpath #(
	parameter int REPLICA_SLOTS = llrp_pkg::SLOTS_DEFAULT,
	parameter int LOAD_BITS     = llrp_pkg::LOAD_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  llrp_pkg::cfg_idx_t                cfg_index,
	input  logic [llrp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [llrp_pkg::REPLICA_W-1:0]    replica,
	input  llrp_pkg::cmd_t                    cmd,
	output llrp_pkg::sts_t                    sts,
	output logic                              granted,
	output logic [llrp_pkg::CHOSEN_W-1:0]     chosen,
	output logic [LOAD_BITS-1:0]              chosen_load
);

	localparam int SLOT_W = (REPLICA_SLOTS > 1) ? $clog2(REPLICA_SLOTS) : 1;
	localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

	// Configuration registers
	logic [llrp_pkg::COUNT_W-1:0] count_q;
	logic [llrp_pkg::TICK_W-1:0]  recovery_q;

	// Slot table
	logic                        healthy_q [REPLICA_SLOTS];
	logic [llrp_pkg::TICK_W-1:0] since_q   [REPLICA_SLOTS];
	logic [LOAD_BITS-1:0]        load_q    [REPLICA_SLOTS];

	// Scan state
	logic [SLOT_W-1:0]            scan_q, best_q;
	logic [LOAD_BITS-1:0]         best_load_q;
	logic                         found_q;
	logic [llrp_pkg::REPLICA_W-1:0] replica_q;

	// Result register
	logic                         granted_q;
	logic [llrp_pkg::CHOSEN_W-1:0] chosen_q;
	logic [LOAD_BITS-1:0]         chosen_load_q;

	logic [llrp_pkg::COUNT_W-1:0] used, new_used;
	logic [SLOT_W-1:0]            idx;
	logic                         rd_healthy, recover, eff_healthy, better, replica_ok;
	logic [llrp_pkg::TICK_W-1:0]  rd_since;
	logic [LOAD_BITS-1:0]         rd_load;
	logic                         cfg_count_wr;

	// Clamp the slot count to the table depth
	assign used = (int'(count_q) > REPLICA_SLOTS) ? llrp_pkg::COUNT_W'(REPLICA_SLOTS) : count_q;
	assign new_used = (int'(cfg_data[llrp_pkg::COUNT_W-1:0]) > REPLICA_SLOTS)
		? llrp_pkg::COUNT_W'(REPLICA_SLOTS) : cfg_data[llrp_pkg::COUNT_W-1:0];
	assign cfg_count_wr = cfg_valid && (cfg_index == llrp_pkg::CFG_REPLICA_COUNT);

	// Single table port: scan slot, best slot or addressed replica
	assign idx = cmd.sel_best ? best_q :
	             (cmd.sel_replica ? SLOT_W'(replica_q) : scan_q);
	assign rd_healthy  = healthy_q[idx];
	assign rd_since    = since_q[idx];
	assign rd_load     = load_q[idx];
	assign recover     = !rd_healthy && (rd_since > recovery_q);
	assign eff_healthy = rd_healthy || recover;
	assign better      = eff_healthy && (!found_q || (rd_load < best_load_q));
	assign replica_ok  = int'(replica_q) < int'(used);

	assign sts.used_empty     = (used == '0);
	assign sts.scan_last_used = (int'(scan_q) + 1) >= int'(used);
	assign sts.scan_last_all  = (scan_q == SLOT_W'(REPLICA_SLOTS - 1));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			recovery_q <= llrp_pkg::RECOVERY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				llrp_pkg::CFG_REPLICA_COUNT:  count_q    <= cfg_data[llrp_pkg::COUNT_W-1:0];
				llrp_pkg::CFG_RECOVERY_TICKS: recovery_q <= cfg_data[llrp_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Slot table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < REPLICA_SLOTS; s++) begin
				healthy_q[s] <= 1'b1;
				since_q[s]   <= '0;
				load_q[s]    <= '0;
			end
		end else begin
			// start newly added slots fresh
			if (cfg_count_wr) begin
				for (int s = 0; s < REPLICA_SLOTS; s++) begin
					if (s >= int'(used) && s < int'(new_used)) begin
						healthy_q[s] <= 1'b1;
						since_q[s]   <= '0;
						load_q[s]    <= '0;
					end
				end
			end
			if (cmd.age && (rd_since != llrp_pkg::TICK_MAX)) begin
				since_q[idx] <= rd_since + 1'b1;
			end
			if (cmd.scan && recover) begin
				healthy_q[idx] <= 1'b1;
			end
			if (cmd.bump && found_q && (rd_load != LOAD_MAX)) begin
				load_q[idx] <= rd_load + 1'b1;
			end
			if (cmd.release_one && replica_ok && (rd_load != '0)) begin
				load_q[idx] <= rd_load - 1'b1;
			end
			if (cmd.fail_one && replica_ok) begin
				healthy_q[idx] <= 1'b0;
				since_q[idx]   <= '0;
			end
		end
	end

	// Scan counter and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.start) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.age || cmd.scan) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.scan && better) begin
				found_q <= 1'b1;
			end
		end
	end

	// Best slot payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q <= '0;
		end else if (cmd.scan && better) begin
			best_q      <= scan_q;
			best_load_q <= rd_load;
		end
		if (cmd.start) begin
			replica_q <= replica;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			granted_q     <= found_q;
			chosen_q      <= found_q ? llrp_pkg::CHOSEN_W'(best_q) : '0;
			chosen_load_q <= found_q ? rd_load : '0;
		end
	end

	assign granted     = granted_q;
	assign chosen      = chosen_q;
	assign chosen_load = chosen_load_q;

	// A bumped grant never leaves the winner at zero load
	a_bump_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bump && found_q) |=> (load_q[best_q] != '0))
		else $error("granted slot load is zero after bump");

	// The running winner stays healthy while it is held
	a_best_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && (cmd.bump || cmd.load_out)) |-> healthy_q[best_q])
		else $error("best slot is not healthy");

	// A result loaded with a grant names a slot in use
	a_grant_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && found_q) |-> (int'(best_q) < int'(used)))
		else $error("granted slot outside the slots in use");

endmodule

// File: rtl/least_loaded_replica_picker_unit.sv
// Least-loaded replica picker: top level joining controller and datapath.
//
// One item is worked on at a time. A tick walks every table slot; a pick walks
// the slots in use one per cycle for recovery and the minimum load, then bumps
// the winner, and goes straight to the result when no slot is in use; a
// release or a fail works on the addressed replica alone. Item steps reach the
// slot table through a single port, one slot per step. Results go to an output
// register, so a finished item waits there while the next one is taken; the
// block stalls only when a second result is ready before the first was taken.
// Configuration writes are taken every cycle and must arrive while the block
// is idle; raising the slot count starts the added slots healthy with zero
// load and zero elapsed ticks.
module least_loaded_replica_picker_unit #(
	parameter int REPLICA_SLOTS = llrp_pkg::SLOTS_DEFAULT,
	parameter int LOAD_BITS     = llrp_pkg::LOAD_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [llrp_pkg::MODE_W-1:0]       mode,
	input  logic [llrp_pkg::REPLICA_W-1:0]    replica,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              granted,
	output logic [llrp_pkg::CHOSEN_W-1:0]     chosen,
	output logic [LOAD_BITS-1:0]              chosen_load,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [llrp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [llrp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	llrp_pkg::cmd_t cmd;
	llrp_pkg::sts_t sts;

	// Configuration writes are always accepted
	assign cfg_ready = 1'b1;

	llrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (llrp_pkg::mode_t'(mode)),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	llrp_dpath #(
		.REPLICA_SLOTS (REPLICA_SLOTS),
		.LOAD_BITS     (LOAD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (llrp_pkg::cfg_idx_t'(cfg_index)),
		.cfg_data    (cfg_data),
		.replica     (replica),
		.cmd         (cmd),
		.sts         (sts),
		.granted     (granted),
		.chosen      (chosen),
		.chosen_load (chosen_load)
	);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the least-loaded replica picker unit.
`timescale 1ns / 100ps

module testbench;
	import llrp_pkg::*;

	localparam int SLOTS        = SLOTS_DEFAULT;
	localparam int LOAD_W       = LOAD_BITS_DEFAULT;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int REPORT_MAX   = 10;

	// One grant as seen on the result port
	typedef struct {
		logic              granted;
		logic [CHOSEN_W-1:0] chosen;
		logic [LOAD_W-1:0] chosen_load;
	} grant_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = MODE_TICK;
	logic [REPLICA_W-1:0] replica = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic granted;
	logic [CHOSEN_W-1:0] chosen;
	logic [LOAD_W-1:0] chosen_load;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_REPLICA_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the slot table and its registers
	logic [COUNT_W-1:0] slot_count;
	logic [TICK_W-1:0] recovery_limit;
	logic slot_healthy [SLOTS];
	logic [TICK_W-1:0] slot_elapsed [SLOTS];
	logic [LOAD_W-1:0] slot_load [SLOTS];

	grant_t pending_grants [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_gap_max = 15;
	int sink_stall_max = 15;
	int sink_wait = 0;

	least_loaded_replica_picker_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.replica    (replica),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.granted    (granted),
		.chosen     (chosen),
		.chosen_load(chosen_load),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int slots_used();
		return (slot_count > SLOTS) ? SLOTS : int'(slot_count);
	endfunction

	function automatic void fresh_slot(int s);
		slot_healthy[s] = 1'b1;
		slot_elapsed[s] = '0;
		slot_load[s] = '0;
	endfunction

	// Apply one register write to the shadow table
	function automatic void apply_register_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		int old_used;
		int new_used;
		if (idx == CFG_REPLICA_COUNT) begin
			old_used = slots_used();
			slot_count = data[COUNT_W-1:0];
			new_used = slots_used();
			for (int s = old_used; s < new_used; s++)
				fresh_slot(s);
		end else begin
			recovery_limit = data[TICK_W-1:0];
		end
	endfunction

	// Advance the shadow table by one request and return the grant it yields
	function automatic grant_t serve_request(mode_t req_mode, logic [REPLICA_W-1:0] req_slot);
		grant_t res;
		int used;
		bit found;
		int best;
		res.granted = 1'b0;
		res.chosen = '0;
		res.chosen_load = '0;
		used = slots_used();
		found = 1'b0;
		best = 0;
		case (req_mode)
			MODE_TICK: begin
				for (int s = 0; s < SLOTS; s++)
					if (slot_elapsed[s] != TICK_MAX)
						slot_elapsed[s]++;
			end
			MODE_PICK: begin
				// recover aged slots, then take the least loaded healthy one
				for (int s = 0; s < used; s++) begin
					if (!slot_healthy[s] && slot_elapsed[s] > recovery_limit)
						slot_healthy[s] = 1'b1;
					if (slot_healthy[s] && (!found || slot_load[s] < slot_load[best])) begin
						best = s;
						found = 1'b1;
					end
				end
				if (found) begin
					if (slot_load[best] != {LOAD_W{1'b1}})
						slot_load[best]++;
					res.granted = 1'b1;
					res.chosen = best[CHOSEN_W-1:0];
					res.chosen_load = slot_load[best];
				end
			end
			MODE_RELEASE: begin
				if (int'(req_slot) < used && slot_load[req_slot] != '0)
					slot_load[req_slot]--;
			end
			default: begin
				if (int'(req_slot) < used) begin
					slot_healthy[req_slot] = 1'b0;
					slot_elapsed[req_slot] = '0;
				end
			end
		endcase
		return res;
	endfunction

	// Send one request; hold valid until it is taken
	task automatic issue_request(mode_t req_mode, logic [REPLICA_W-1:0] req_slot);
		int gap;
		grant_t want_grant;
		gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= req_mode;
		replica <= req_slot;
		do @(posedge clk); while (!in_ready);
		want_grant = serve_request(req_mode, req_slot);
		pending_grants = {pending_grants, want_grant};
	endtask

	// Drop valid and wait until every expected grant is back
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register_write(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Check each grant against the oldest expectation; stall the sink at random
	always @(posedge clk) begin : check_grants
		grant_t want;
		logic ready_next;
		ready_next = out_ready;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected item: granted %0d chosen %0d load %0d",
						granted, chosen, chosen_load);
			end else begin
				want = pending_grants.pop_front();
				if (granted !== want.granted || chosen !== want.chosen ||
						chosen_load !== want.chosen_load) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("mismatch: exp granted %0d chosen %0d load %0d, got %0d %0d %0d",
							want.granted, want.chosen, want.chosen_load,
							granted, chosen, chosen_load);
				end
			end
			sink_wait = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
			ready_next = (sink_wait == 0);
		end else if (!out_ready) begin
			if (sink_wait > 0)
				sink_wait--;
			if (sink_wait == 0)
				ready_next = 1'b1;
		end
		out_ready <= ready_next;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("least_loaded_replica_picker_unit regression: fail");
			$finish;
		end
	end

	// Reset state, tie-break, release at zero, unused slots and recovery
	task automatic test_basic_flow();
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_TICK, 4'd15);
		issue_request(MODE_RELEASE, 4'd0);
		issue_request(MODE_FAIL, 4'd0);
		wait_results_done();
		write_register(CFG_REPLICA_COUNT, 32'd3);
		write_register(CFG_RECOVERY_TICKS, 32'd1);
		repeat (4) issue_request(MODE_PICK, 4'd15);
		issue_request(MODE_RELEASE, 4'd1);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_RELEASE, 4'd2);
		issue_request(MODE_RELEASE, 4'd2);
		issue_request(MODE_RELEASE, 4'd15);
		issue_request(MODE_FAIL, 4'd15);
		issue_request(MODE_FAIL, 4'd2);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_TICK, 4'd0);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_TICK, 4'd0);
		issue_request(MODE_PICK, 4'd0);
		wait_results_done();
	endtask

	// Register extremes: zero and never recovery, count above slots, grow and shrink
	task automatic test_register_extremes();
		write_register(CFG_RECOVERY_TICKS, 32'd0);
		issue_request(MODE_FAIL, 4'd0);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_TICK, 4'd0);
		issue_request(MODE_PICK, 4'd0);
		wait_results_done();
		write_register(CFG_RECOVERY_TICKS, TICK_MAX);
		write_register(CFG_REPLICA_COUNT, 32'd20);
		issue_request(MODE_FAIL, 4'd15);
		issue_request(MODE_TICK, 4'd0);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_RELEASE, 4'd15);
		wait_results_done();
		write_register(CFG_REPLICA_COUNT, 32'd31);
		write_register(CFG_REPLICA_COUNT, 32'd2);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_FAIL, 4'd9);
		wait_results_done();
		write_register(CFG_REPLICA_COUNT, 32'd16);
		issue_request(MODE_PICK, 4'd0);
		issue_request(MODE_PICK, 4'd0);
		wait_results_done();
		write_register(CFG_REPLICA_COUNT, 32'd0);
		write_register(CFG_REPLICA_COUNT, 32'd5);
		issue_request(MODE_PICK, 4'd0);
		wait_results_done();
	endtask

	// Random requests over a series of register settings
	task automatic test_random_traffic();
		int roll;
		int used;
		logic [CFG_DATA_W-1:0] count_val;
		logic [CFG_DATA_W-1:0] recovery_val;
		mode_t req_mode;
		logic [REPLICA_W-1:0] req_slot;
		for (int phase = 0; phase < 10; phase++) begin
			wait_results_done();
			roll = $urandom_range(0, 9);
			if (roll == 0)
				count_val = 32'd0;
			else if (roll == 1)
				count_val = 32'd16;
			else if (roll == 2)
				count_val = $urandom_range(17, 31);
			else
				count_val = $urandom_range(1, 15);
			roll = $urandom_range(0, 9);
			if (roll == 0)
				recovery_val = '0;
			else if (roll == 1)
				recovery_val = TICK_MAX;
			else if (roll == 2)
				recovery_val = RECOVERY_RESET;
			else if (roll == 3)
				recovery_val = $urandom;
			else
				recovery_val = $urandom_range(0, 6);
			// now and then write a random count first, so that a grow after a shrink clears slots
			if ($urandom_range(0, 2) == 0)
				write_register(CFG_REPLICA_COUNT, $urandom_range(0, 31));
			write_register(CFG_RECOVERY_TICKS, recovery_val);
			write_register(CFG_REPLICA_COUNT, count_val);
			send_gap_max = (phase % 3 == 2) ? 0 : 15;
			sink_stall_max = (phase % 3 == 2) ? 0 : 15;
			for (int n = 0; n < 120; n++) begin
				// let the pipe run dry once in a while
				if (n == 60 && phase % 2 == 0)
					wait_results_done();
				roll = $urandom_range(0, 99);
				if (roll < 45)
					req_mode = MODE_PICK;
				else if (roll < 70)
					req_mode = MODE_RELEASE;
				else if (roll < 83)
					req_mode = MODE_TICK;
				else
					req_mode = MODE_FAIL;
				used = slots_used();
				if (used > 0 && $urandom_range(0, 4) != 0)
					req_slot = REPLICA_W'($urandom_range(0, used - 1));
				else
					req_slot = REPLICA_W'($urandom_range(0, 15));
				issue_request(req_mode, req_slot);
			end
		end
		send_gap_max = 15;
		sink_stall_max = 15;
	endtask

	initial begin
		slot_count = '0;
		recovery_limit = RECOVERY_RESET;
		for (int s = 0; s < SLOTS; s++)
			fresh_slot(s);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_flow();
		test_register_extremes();
		test_random_traffic();
		wait_results_done();
		if (mismatch_count == 0)
			$display("least_loaded_replica_picker_unit regression: pass");
		else
			$display("least_loaded_replica_picker_unit regression: fail");
		$finish;
	end

endmodule
